// ----- src/rflr_pkg.sv -----
// rflr_pkg: operation codes, line-end constant and controller/datapath structs
// for the receive FIFO with line resync. No dependencies.
package rflr_pkg;

    typedef enum logic [1:0] {
        FN_RX    = 2'd0,
        FN_POP   = 2'd1,
        FN_TAKE  = 2'd2,
        FN_FLUSH = 2'd3
    } t_func;

    localparam logic [7:0] LINE_END = 8'h0A;
    localparam int unsigned FILL_W  = 7;

    typedef struct packed {
        logic exec;
        logic wr_en;
        logic pop_hit;
        logic take_hit;
        logic set_drop;
        logic clr_drop;
        logic set_pend;
        logic flush;
    } t_dp_cmd;

    typedef struct packed {
        logic empty;
        logic full;
        logic dropping;
        logic pending;
        logic newline;
    } t_dp_status;

endpackage

// ----- src/rx_fifo_line_resync.sv -----
// rx_fifo_line_resync: receive byte FIFO that drops input after an overflow
// until the next newline, then flags a pending overflow report.
// Timing: a result is valid in the cycle after its beat is accepted.
// Throughput: 1 beat per cycle while each result is taken (i_ready); the byte store read is registered.
// Reset: synchronous active-low; clears pointers, flags and the result stage.
// Store contents are not cleared; unwritten slots are never read.
module rx_fifo_line_resync
    import rflr_pkg::*;
#(
    parameter int RING_DEPTH = 128
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [1:0] i_func,
    input  logic [7:0] i_rx_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output logic       o_pop_valid,
    output logic [7:0] o_pop_byte,
    output logic       o_report_taken,
    output logic       o_dropping,
    output logic [6:0] o_fill_level
);

    t_dp_cmd    cmd;
    t_dp_status status;

    rflr_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .i_func   (i_func),
        .i_status (status),
        .o_cmd    (cmd)
    );

    rflr_dp #(
        .RING_DEPTH (RING_DEPTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_rx_byte      (i_rx_byte),
        .i_cmd          (cmd),
        .o_status       (status),
        .o_pop_valid    (o_pop_valid),
        .o_pop_byte     (o_pop_byte),
        .o_report_taken (o_report_taken),
        .o_dropping     (o_dropping),
        .o_fill_level   (o_fill_level)
    );

endmodule

// ----- src/rflr_ram.sv -----
// rflr_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module rflr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- src/rflr_ctrl.sv -----
// rflr_ctrl: handshake controller and operation decoder for the resync FIFO.
// Depends on rflr_pkg.
module rflr_ctrl
    import rflr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    output logic       o_valid,
    input  logic       i_ready,
    input  logic [1:0] i_func,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    typedef enum logic {
        S_EMPTY,
        S_HOLD
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign o_ready = (r_state == S_EMPTY) || i_ready;
    assign o_valid = (r_state == S_HOLD);
    assign accept  = i_valid && o_ready;

    always_comb begin
        o_cmd      = '0;
        o_cmd.exec = accept;
        if (accept) begin
            unique case (t_func'(i_func))
                FN_RX: begin
                    if (i_status.dropping) begin
                        o_cmd.clr_drop = i_status.newline;
                        o_cmd.set_pend = i_status.newline;
                    end else if (i_status.full) begin
                        o_cmd.set_drop = 1'b1;
                    end else begin
                        o_cmd.wr_en = 1'b1;
                    end
                end
                FN_POP:   o_cmd.pop_hit  = !i_status.empty;
                FN_TAKE:  o_cmd.take_hit = i_status.pending;
                FN_FLUSH: o_cmd.flush    = 1'b1;
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        if (accept) begin
            n_state = S_HOLD;
        end else if (i_ready) begin
            n_state = S_EMPTY;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_EMPTY;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- src/rflr_dp.sv -----
// rflr_dp: ring pointers, drop/report flags, byte store and result registers.
// Depends on rflr_pkg and rflr_ram.
module rflr_dp
    import rflr_pkg::*;
#(
    parameter int RING_DEPTH = 128
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [7:0]        i_rx_byte,
    input  t_dp_cmd           i_cmd,
    output t_dp_status        o_status,
    output logic              o_pop_valid,
    output logic [7:0]        o_pop_byte,
    output logic              o_report_taken,
    output logic              o_dropping,
    output logic [FILL_W-1:0] o_fill_level
);

    localparam int PTR_W  = $clog2(RING_DEPTH);
    localparam int CNT_W  = PTR_W + 1;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);
    localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(RING_DEPTH);

    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic             r_drop;
    logic             r_pend;
    logic             r_pop_valid;
    logic             r_taken;
    logic [PTR_W-1:0] wr_next;
    logic [PTR_W-1:0] rd_next;
    logic [CNT_W-1:0] fill;
    logic [7:0]       rd_data;

    assign wr_next = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
    assign rd_next = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;

    assign o_status.empty    = (r_wr_ptr == r_rd_ptr);
    assign o_status.full     = (wr_next == r_rd_ptr);
    assign o_status.dropping = r_drop;
    assign o_status.pending  = r_pend;
    assign o_status.newline  = (i_rx_byte == LINE_END);

    always_comb begin
        if (r_wr_ptr >= r_rd_ptr) begin
            fill = CNT_W'(r_wr_ptr) - CNT_W'(r_rd_ptr);
        end else begin
            fill = CNT_W'(r_wr_ptr) + DEPTH_C - CNT_W'(r_rd_ptr);
        end
    end

    rflr_ram #(
        .WIDTH (8),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.wr_en),
        .i_wr_addr (r_wr_ptr),
        .i_wr_data (i_rx_byte),
        .i_rd_en   (i_cmd.pop_hit),
        .i_rd_addr (r_rd_ptr),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr    <= '0;
            r_rd_ptr    <= '0;
            r_drop      <= 1'b0;
            r_pend      <= 1'b0;
            r_pop_valid <= 1'b0;
            r_taken     <= 1'b0;
        end else if (i_cmd.exec) begin
            r_pop_valid <= i_cmd.pop_hit;
            r_taken     <= i_cmd.take_hit;
            if (i_cmd.flush) begin
                r_wr_ptr <= '0;
                r_rd_ptr <= '0;
                r_drop   <= 1'b0;
                r_pend   <= 1'b0;
            end else begin
                if (i_cmd.wr_en) begin
                    r_wr_ptr <= wr_next;
                end
                if (i_cmd.pop_hit) begin
                    r_rd_ptr <= rd_next;
                end
                if (i_cmd.set_drop) begin
                    r_drop <= 1'b1;
                end else if (i_cmd.clr_drop) begin
                    r_drop <= 1'b0;
                end
                if (i_cmd.set_pend) begin
                    r_pend <= 1'b1;
                end else if (i_cmd.take_hit) begin
                    r_pend <= 1'b0;
                end
            end
        end
    end

    assign o_pop_valid    = r_pop_valid;
    assign o_pop_byte     = r_pop_valid ? rd_data : 8'h00;
    assign o_report_taken = r_taken;
    assign o_dropping     = r_drop;
    assign o_fill_level   = FILL_W'(fill);

endmodule
